>>> hdl/lge_pkg.sv
`default_nettype none

package lge_pkg;

   localparam int ROW_BITS  = 64;
   localparam int STORE_ROWS = 64;
   localparam int IDX_BITS  = 6;
   localparam int DIM_BITS  = 7;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_STEP  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_LOW   = 4'd2;
   localparam logic [3:0] SURVIVE_HIGH  = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_OUT,
      ST_LOAD,
      ST_ROW
   } state_type;

   typedef enum logic [1:0] {
      ADDR_REQ,
      ADDR_ZERO,
      ADDR_NEXT
   } addr_sel_type;

   typedef struct packed {
      logic         write_row;
      logic         rd_en;
      addr_sel_type addr_sel;
      logic         load_idx;
      logic         clear_all;
      logic         start_step;
      logic         load_here;
      logic         commit_row;
      logic         emit_read;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic height_zero;
      logic last_row;
   } status_type;

   // Next state of one cell from its eight neighbors under B3/S23.
   function automatic logic life_next(logic alive, logic [7:0] nbr);
      logic [3:0] cnt;
      cnt = 4'd0;
      for (int i = 0; i < 8; i++) begin
         cnt = cnt + {3'd0, nbr[i]};
      end
      if (alive) begin
         return (cnt >= SURVIVE_LOW) && (cnt <= SURVIVE_HIGH);
      end
      return cnt == BIRTH_COUNT;
   endfunction

endpackage

`default_nettype wire

>>> hdl/lge_ctrl.sv
`default_nettype none

module lge_ctrl
   import lge_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_opcode,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.addr_sel = ADDR_NEXT;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (req_opcode)
                  OP_WRITE: begin
                     cmd.write_row = 1'b1;
                  end
                  OP_READ: begin
                     cmd.rd_en    = 1'b1;
                     cmd.addr_sel = ADDR_REQ;
                     cmd.load_idx = 1'b1;
                     state_in     = ST_READ_OUT;
                  end
                  OP_STEP: begin
                     if (status.height_zero) begin
                        cmd.clear_all = 1'b1;
                     end else begin
                        cmd.rd_en      = 1'b1;
                        cmd.addr_sel   = ADDR_ZERO;
                        cmd.start_step = 1'b1;
                        state_in       = ST_LOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ_OUT: begin
            if (status.out_free) begin
               cmd.emit_read = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd.load_here = 1'b1;
            cmd.rd_en     = 1'b1;
            state_in      = ST_ROW;
         end
         ST_ROW: begin
            if (status.out_free) begin
               cmd.commit_row = 1'b1;
               cmd.rd_en      = 1'b1;
               if (status.last_row) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/lge_datapath.sv
`default_nettype none

module lge_datapath
   import lge_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [IDX_BITS-1:0]  req_row_index,
   input  wire logic [ROW_BITS-1:0]  req_row_cells,
   input  wire logic                 csr_write_enable,
   input  wire logic                 csr_index,
   input  wire logic [DIM_BITS-1:0]  csr_write_data,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output logic [IDX_BITS-1:0]       rsp_out_row_index,
   output logic [ROW_BITS-1:0]       rsp_out_row_cells,
   output logic                      rsp_last_row,
   input  wire cmd_type              cmd,
   output status_type                status
);

   localparam int WIDTH_CAP  = (MAX_WIDTH < ROW_BITS) ? MAX_WIDTH : ROW_BITS;
   localparam int HEIGHT_CAP = (MAX_HEIGHT < STORE_ROWS) ? MAX_HEIGHT : STORE_ROWS;
   localparam logic [DIM_BITS-1:0] WCAP = DIM_BITS'(WIDTH_CAP);
   localparam logic [DIM_BITS-1:0] HCAP = DIM_BITS'(HEIGHT_CAP);

   logic [DIM_BITS-1:0] width_ff;
   logic [DIM_BITS-1:0] height_ff;
   logic [DIM_BITS-1:0] eff_w;
   logic [DIM_BITS-1:0] eff_h;
   logic [ROW_BITS-1:0] col_mask;

   logic [ROW_BITS-1:0] mem [STORE_ROWS];
   logic [STORE_ROWS-1:0] valid_ff;
   logic [ROW_BITS-1:0] rd_data_ff;
   logic                rd_valid_ff;
   logic [ROW_BITS-1:0] rd_row;
   logic [IDX_BITS-1:0] rd_addr;

   logic [IDX_BITS-1:0] idx_ff;
   logic [DIM_BITS-1:0] row_ff;
   logic [DIM_BITS-1:0] row_in;
   logic [DIM_BITS-1:0] row_plus;
   logic [ROW_BITS-1:0] above_ff;
   logic [ROW_BITS-1:0] here_ff;
   logic [ROW_BITS-1:0] below;
   logic [ROW_BITS-1:0] fresh;

   logic [ROW_BITS+1:0] above_p;
   logic [ROW_BITS+1:0] here_p;
   logic [ROW_BITS+1:0] below_p;

   logic                wr_en;
   logic [IDX_BITS-1:0] wr_addr;
   logic [ROW_BITS-1:0] wr_data;

   logic                out_valid_ff;
   logic [IDX_BITS-1:0] out_idx_ff;
   logic [ROW_BITS-1:0] out_cells_ff;
   logic                out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_BITS'(ROW_BITS);
         height_ff <= DIM_BITS'(STORE_ROWS);
      end else if (csr_write_enable) begin
         if (csr_index == CSR_GRID_WIDTH) begin
            width_ff <= csr_write_data;
         end else begin
            height_ff <= csr_write_data;
         end
      end
   end

   assign eff_w = (width_ff > WCAP) ? WCAP : width_ff;
   assign eff_h = (height_ff > HCAP) ? HCAP : height_ff;

   always_comb begin
      for (int x = 0; x < ROW_BITS; x++) begin
         col_mask[x] = DIM_BITS'(x) < eff_w;
      end
   end

   assign row_plus = row_ff + DIM_BITS'(1);
   assign row_in   = cmd.commit_row ? row_plus : row_ff;

   always_comb begin
      case (cmd.addr_sel)
         ADDR_REQ:  rd_addr = req_row_index;
         ADDR_ZERO: rd_addr = '0;
         ADDR_NEXT: rd_addr = row_in[IDX_BITS-1:0] + IDX_BITS'(1);
         default:   rd_addr = '0;
      endcase
   end

   // Rows never written since reset or since a step dropped them read as dead.
   assign rd_row = rd_valid_ff ? (rd_data_ff & col_mask) : '0;
   assign below  = (row_plus < eff_h) ? rd_row : '0;

   assign above_p = {1'b0, above_ff, 1'b0};
   assign here_p  = {1'b0, here_ff, 1'b0};
   assign below_p = {1'b0, below, 1'b0};

   always_comb begin
      for (int x = 0; x < ROW_BITS; x++) begin
         fresh[x] = col_mask[x] & life_next(here_p[x+1],
            {above_p[x], above_p[x+1], above_p[x+2], here_p[x], here_p[x+2],
             below_p[x], below_p[x+1], below_p[x+2]});
      end
   end

   assign wr_en   = cmd.write_row | cmd.commit_row;
   assign wr_addr = cmd.write_row ? req_row_index : row_ff[IDX_BITS-1:0];
   assign wr_data = cmd.write_row ? req_row_cells : fresh;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
         if (cmd.clear_all) begin
            valid_ff <= '0;
         end else begin
            for (int k = 0; k < STORE_ROWS; k++) begin
               if (cmd.commit_row && status.last_row && DIM_BITS'(k) >= eff_h) begin
                  valid_ff[k] <= 1'b0;
               end
            end
            if (wr_en) begin
               valid_ff[wr_addr] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_idx) begin
         idx_ff <= req_row_index;
      end
      if (cmd.start_step) begin
         row_ff   <= '0;
         above_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
      if (cmd.load_here) begin
         here_ff <= rd_row;
      end else if (cmd.commit_row) begin
         above_ff <= here_ff;
         here_ff  <= below;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_read || cmd.commit_row) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_read) begin
         out_idx_ff   <= idx_ff;
         out_cells_ff <= ({1'b0, idx_ff} < eff_h) ? rd_row : '0;
         out_last_ff  <= 1'b1;
      end else if (cmd.commit_row) begin
         out_idx_ff   <= row_ff[IDX_BITS-1:0];
         out_cells_ff <= fresh;
         out_last_ff  <= status.last_row;
      end
   end

   assign status.out_free    = !out_valid_ff || !rsp_stall;
   assign status.height_zero = eff_h == '0;
   assign status.last_row    = row_plus == eff_h;

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_row_index = out_idx_ff;
   assign rsp_out_row_cells = out_cells_ff;
   assign rsp_last_row      = out_last_ff;

endmodule

`default_nettype wire

>>> hdl/life_generation_engine_top.sv
`default_nettype none

// Bounded Conway grid engine, B3/S23, up to 64 rows of 64 cells.
// Input channel (req_): one item per operation. A write item stores
// req_row_cells at req_row_index and gives no result. A read item gives one
// result with that row masked to the columns in use and rsp_last_row set.
// A step item advances the grid one generation and gives one result per row
// in use, from row 0 up, with rsp_last_row on the final one.
// Configuration (csr_): index 0 sets the grid width, index 1 the height;
// write them only while the block is idle.
// Without stalls a write is stored as it is accepted, a read fetches its row
// and then registers the result, and a step is accepted, primes the line buffer,
// then gives one row a cycle through the row of cell lanes, paced by the
// single row read port. Reset clears the row valid flags, so every cell
// reads dead, and sets width and height to 64.
// The result register lets a new item be accepted while a result waits.
// While a result waits under rsp_stall the step pauses on its row and the result
// holds; req_stall stays high until the operation has handed off its last row.
module life_generation_engine_top
   import lge_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [IDX_BITS-1:0]  req_row_index,
   input  wire logic [ROW_BITS-1:0]  req_row_cells,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [IDX_BITS-1:0]       rsp_out_row_index,
   output logic [ROW_BITS-1:0]       rsp_out_row_cells,
   output logic                      rsp_last_row,
   input  wire logic                 csr_write_enable,
   input  wire logic                 csr_index,
   input  wire logic [DIM_BITS-1:0]  csr_write_data
);

   cmd_type    cmd;
   status_type status;

   lge_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   lge_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_row_index     (req_row_index),
      .req_row_cells     (req_row_cells),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_out_row_index (rsp_out_row_index),
      .rsp_out_row_cells (rsp_out_row_cells),
      .rsp_last_row      (rsp_last_row),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

`default_nettype wire

>>> hdl/lge_checker.sv
`default_nettype none

module lge_checker
   import lge_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic [1:0]          req_opcode,
   input wire logic [IDX_BITS-1:0] req_row_index,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [IDX_BITS-1:0] rsp_out_row_index,
   input wire logic                rsp_last_row
);

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A write item never produces a result.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_take && req_opcode == OP_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("write item produced a result");

   // With no result waiting, a read answers after its row read.
   a_read_answer: assert property (@(posedge clock) disable iff (reset)
      req_take && req_opcode == OP_READ && !rsp_valid |=> ##1
         (rsp_valid && rsp_last_row && rsp_out_row_index == $past(req_row_index, 2)))
      else $error("read result missing or wrong");

endmodule

bind life_generation_engine_top lge_checker u_lge_checker (.*);

`default_nettype wire

>>> bench/life_generation_engine_top_tb.sv
module life_generation_engine_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lge_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int PRINT_CAP     = 40;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 36;

   // The block ignores this opcode; it is sent on purpose.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]          opcode;
      logic [IDX_BITS-1:0] row;
      logic [ROW_BITS-1:0] cells;
   } grid_cmd_type;

   typedef struct {
      logic [IDX_BITS-1:0] row;
      logic [ROW_BITS-1:0] cells;
      logic                last;
   } row_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_opcode = OP_WRITE;
   logic [IDX_BITS-1:0] req_row_index = '0;
   logic [ROW_BITS-1:0] req_row_cells = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [IDX_BITS-1:0] rsp_out_row_index;
   logic [ROW_BITS-1:0] rsp_out_row_cells;
   logic                rsp_last_row;
   logic                csr_write_enable = 1'b0;
   logic                csr_index = CSR_GRID_WIDTH;
   logic [DIM_BITS-1:0] csr_write_data = '0;

   grid_cmd_type     queued_cmds[$];
   row_result_type   expected_rows[$];

   logic [ROW_BITS-1:0] grid_model[STORE_ROWS];
   logic [DIM_BITS-1:0] model_width  = DIM_BITS'(64);
   logic [DIM_BITS-1:0] model_height = DIM_BITS'(64);

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  send_calm = 1'b0;
   bit  rsp_calm = 1'b0;

   life_generation_engine_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_row_index     (req_row_index),
      .req_row_cells     (req_row_cells),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_row_index (rsp_out_row_index),
      .rsp_out_row_cells (rsp_out_row_cells),
      .rsp_last_row      (rsp_last_row),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      foreach (grid_model[i]) grid_model[i] = '0;
   end

   function automatic int idle_len(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 15);
   endfunction

   function automatic logic [ROW_BITS-1:0] random_cells();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return {$urandom() & $urandom(), $urandom() & $urandom()};
         4: return {$urandom() | $urandom(), $urandom() | $urandom()};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic int live_at(logic [ROW_BITS-1:0] cells, int x, int w);
      if (x < 0 || x >= w) return 0;
      return int'(cells[x]);
   endfunction

   function automatic void expect_row(row_result_type r);
      expected_rows.insert(expected_rows.size(), r);
   endfunction

   // Updates the grid copy for one accepted item and queues the rows it must produce.
   function automatic void apply_grid_cmd(grid_cmd_type c);
      int w, h, cnt;
      logic [ROW_BITS-1:0] mask, above, here, below, fresh;
      row_result_type r;
      w = (model_width > ROW_BITS) ? ROW_BITS : int'(model_width);
      h = (model_height > STORE_ROWS) ? STORE_ROWS : int'(model_height);
      mask = (w >= ROW_BITS) ? '1 : ((64'd1 << w) - 64'd1);
      case (c.opcode)
         OP_WRITE: grid_model[c.row] = c.cells;
         OP_READ: begin
            r.row = c.row;
            r.cells = (c.row < h) ? (grid_model[c.row] & mask) : '0;
            r.last = 1'b1;
            expect_row(r);
         end
         OP_STEP: begin
            above = '0;
            here = (h > 0) ? (grid_model[0] & mask) : '0;
            for (int y = 0; y < STORE_ROWS; y++) begin
               if (y >= h) begin
                  grid_model[y] = '0;
               end else begin
                  below = (y + 1 < h) ? (grid_model[y + 1] & mask) : '0;
                  fresh = '0;
                  for (int x = 0; x < w; x++) begin
                     cnt = 0;
                     for (int dx = -1; dx <= 1; dx++) begin
                        cnt += live_at(above, x + dx, w) + live_at(below, x + dx, w);
                        if (dx != 0) cnt += live_at(here, x + dx, w);
                     end
                     if (here[x])
                        fresh[x] = (cnt >= SURVIVE_LOW) && (cnt <= SURVIVE_HIGH);
                     else
                        fresh[x] = (cnt == BIRTH_COUNT);
                  end
                  grid_model[y] = fresh;
                  above = here;
                  here = below;
                  r.row = IDX_BITS'(y);
                  r.cells = fresh;
                  r.last = (y + 1 == h);
                  expect_row(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic flag_mismatch(string what);
      // Printing is capped so a badly broken block cannot flood the log.
      if (mismatch_count < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic write_csr(logic idx, int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= DIM_BITS'(value);
      if (idx == CSR_GRID_WIDTH) model_width = DIM_BITS'(value);
      else model_height = DIM_BITS'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_dims(int w, int h);
      write_csr(CSR_GRID_WIDTH, w);
      write_csr(CSR_GRID_HEIGHT, h);
   endtask

   task automatic queue_cmd(logic [1:0] op, int row, logic [ROW_BITS-1:0] cells);
      grid_cmd_type c;
      c.opcode = op;
      c.row = IDX_BITS'(row);
      c.cells = cells;
      queued_cmds.insert(queued_cmds.size(), c);
   endtask

   // Sampled at the falling edge so that this edge's updates have all settled.
   task automatic wait_for_idle();
      do @(negedge clock);
      while (queued_cmds.size() != 0 || req_valid || expected_rows.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: presents queued items, with random gaps after each accepted item.
   always @(posedge clock) begin
      grid_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (queued_cmds.size() > 0) begin
            c = queued_cmds.pop_front();
            req_valid <= 1'b1;
            req_opcode <= c.opcode;
            req_row_index <= c.row;
            req_row_cells <= c.cells;
            send_gap <= idle_len(send_calm);
            if ($urandom_range(0, 39) == 0) send_calm <= !send_calm;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall: every stall run ends with rsp_stall dropped before a new run can start.
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
      end else begin
         n = idle_len(rsp_calm);
         rsp_stall <= (n > 0);
         stall_left <= (n > 0) ? n - 1 : 0;
         if ($urandom_range(0, 59) == 0) rsp_calm <= !rsp_calm;
      end
   end

   // Results are checked before the item taken at the same edge is predicted.
   always @(posedge clock) begin
      row_result_type want;
      grid_cmd_type taken;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               flag_mismatch($sformatf("unexpected row %0d", rsp_out_row_index));
            end else begin
               want = expected_rows.pop_front();
               if (rsp_out_row_index !== want.row)
                  flag_mismatch($sformatf("row index %0d, expected %0d",
                                          rsp_out_row_index, want.row));
               if (rsp_out_row_cells !== want.cells)
                  flag_mismatch($sformatf("row %0d cells %h, expected %h",
                                          want.row, rsp_out_row_cells, want.cells));
               if (rsp_last_row !== want.last)
                  flag_mismatch($sformatf("row %0d last flag %b, expected %b",
                                          want.row, rsp_last_row, want.last));
            end
         end
         if (req_valid && !req_stall) begin
            taken.opcode = req_opcode;
            taken.row = req_row_index;
            taken.cells = req_row_cells;
            apply_grid_cmd(taken);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int w_pick, h_pick, eff_h, pick;
      logic [1:0] op;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Full 64 by 64 grid out of reset: edge columns, edge rows, ignored opcode.
      queue_cmd(OP_WRITE, 0, '1);
      queue_cmd(OP_WRITE, 63, '1);
      queue_cmd(OP_WRITE, 1, 64'h8000_0000_0000_0001);
      queue_cmd(OP_WRITE, 32, random_cells());
      queue_cmd(OP_UNUSED, 7, random_cells());
      queue_cmd(OP_READ, 63, '0);
      queue_cmd(OP_READ, 5, '0);
      queue_cmd(OP_STEP, 0, '0);
      queue_cmd(OP_READ, 0, '0);
      wait_for_idle();

      // No column in use: reads are empty and a step kills everything.
      set_dims(0, 64);
      queue_cmd(OP_READ, 1, '0);
      queue_cmd(OP_STEP, 0, '1);
      wait_for_idle();

      // Oversized settings saturate; a glider on an otherwise dead grid.
      set_dims(127, 127);
      queue_cmd(OP_WRITE, 10, 64'h2);
      queue_cmd(OP_WRITE, 11, 64'h4);
      queue_cmd(OP_WRITE, 12, 64'h7);
      queue_cmd(OP_STEP, 0, '0);
      queue_cmd(OP_READ, 12, '0);
      wait_for_idle();

      // Single cell grid, plus a read beyond the rows in use.
      set_dims(1, 1);
      queue_cmd(OP_WRITE, 0, '1);
      queue_cmd(OP_READ, 0, '0);
      queue_cmd(OP_READ, 40, '0);
      queue_cmd(OP_STEP, 0, '0);
      wait_for_idle();

      // No row in use: a step clears the store and gives nothing back.
      set_dims(64, 0);
      queue_cmd(OP_WRITE, 2, '1);
      queue_cmd(OP_STEP, 0, '0);
      queue_cmd(OP_READ, 2, '0);
      wait_for_idle();

      set_dims(64, 64);
      queue_cmd(OP_READ, 2, '0);
      wait_for_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            w_pick = 64;
            h_pick = 64;
         end else begin
            case ($urandom_range(0, 7))
               0: w_pick = 1;
               1: w_pick = $urandom_range(2, 6);
               2: w_pick = 64;
               3: w_pick = $urandom_range(65, 127);
               default: w_pick = $urandom_range(3, 63);
            endcase
            case ($urandom_range(0, 7))
               0: h_pick = 1;
               1: h_pick = $urandom_range(2, 6);
               2: h_pick = 64;
               3: h_pick = $urandom_range(65, 127);
               4: h_pick = 0;
               default: h_pick = $urandom_range(3, 24);
            endcase
         end
         set_dims(w_pick, h_pick);
         eff_h = (h_pick > STORE_ROWS) ? STORE_ROWS : h_pick;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Now and then the sender holds off until every row has come back.
            if (i == PHASE_ITEMS / 2 && (p == 0 || $urandom_range(0, 2) == 0))
               wait_for_idle();
            pick = $urandom_range(0, 99);
            if (pick < 5) op = OP_UNUSED;
            else if (pick < 45) op = OP_WRITE;
            else if (pick < 65) op = OP_STEP;
            else op = OP_READ;
            if (eff_h == 0 || $urandom_range(0, 4) == 0)
               queue_cmd(op, $urandom_range(0, 63), random_cells());
            else
               queue_cmd(op, $urandom_range(0, eff_h - 1), random_cells());
         end
         wait_for_idle();
      end

      wait_for_idle();
      if (mismatch_count == 0 && expected_rows.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
